// File: sv/lcdw_pkg.sv
// Shared types and constants for the LRU store with dirty write-back.
// No dependencies; used by every module of the block.
package lcdw_pkg;

    // Default sizes of the store
    localparam int ENTRIES_DEF    = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Configuration register
    localparam int             CAP_BITS  = 7;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PUT       = 2'd0,
        CMD_GET       = 2'd1,
        CMD_SET_DIRTY = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    // Execution sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MATCH = 2'd1,
        S_READ  = 2'd2,
        S_EXEC  = 2'd3
    } state_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_ctl_t;

endpackage

// File: sv/lcdw_front.sv
// Front end: accepts items, decodes the command, holds them in a two-entry queue.
// Depends on lcdw_pkg.
module lcdw_front #(
    parameter int KEY_BITS   = lcdw_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lcdw_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_value,
    output lcdw_pkg::q_ctl_t      q_ctl,
    output logic [KEY_BITS-1:0]   q_key,
    output logic [VALUE_BITS-1:0] q_value,
    input  logic                  q_pop
);

    lcdw_pkg::cmd_t          cmd_q_reg [2];
    logic [KEY_BITS-1:0]     key_q_reg [2];
    logic [VALUE_BITS-1:0]   val_q_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              count_reg, count_next;
    logic                    push;
    logic                    pop;
    lcdw_pkg::cmd_t          cmd_dec;

    // Command decode
    always_comb begin
        unique case (s_command)
            lcdw_pkg::CMD_PUT:       cmd_dec = lcdw_pkg::CMD_PUT;
            lcdw_pkg::CMD_GET:       cmd_dec = lcdw_pkg::CMD_GET;
            lcdw_pkg::CMD_SET_DIRTY: cmd_dec = lcdw_pkg::CMD_SET_DIRTY;
            default:                 cmd_dec = lcdw_pkg::CMD_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (count_reg != 2'd0);

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_q_reg[wr_ptr_reg] <= cmd_dec;
            key_q_reg[wr_ptr_reg] <= s_key;
            val_q_reg[wr_ptr_reg] <= s_value;
        end
    end

    assign q_ctl.valid = (count_reg != 2'd0);
    assign q_ctl.cmd   = cmd_q_reg[rd_ptr_reg];
    assign q_key       = key_q_reg[rd_ptr_reg];
    assign q_value     = val_q_reg[rd_ptr_reg];

endmodule

// File: sv/lcdw_back.sv
// Back end: key match, recency ranks, dirty marks, value/key memories, result register.
// Depends on lcdw_pkg.
module lcdw_back #(
    parameter int ENTRIES    = lcdw_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lcdw_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lcdw_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lcdw_pkg::CAP_BITS-1:0]   capacity,
    input  lcdw_pkg::q_ctl_t                q_ctl,
    input  logic [KEY_BITS-1:0]             q_key,
    input  logic [VALUE_BITS-1:0]           q_value,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [VALUE_BITS-1:0]           m_read_value,
    output logic                            m_victim_valid,
    output logic [KEY_BITS-1:0]             m_victim_key,
    output logic [VALUE_BITS-1:0]           m_victim_value
);

    localparam int IW = $clog2(ENTRIES);
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > lcdw_pkg::CAP_BITS) ? UW : lcdw_pkg::CAP_BITS;
    localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

    // Sequencer
    lcdw_pkg::state_t state_reg, state_next;
    logic             exec_fire;

    // Item being worked on
    lcdw_pkg::cmd_t          cmd_reg;
    logic [KEY_BITS-1:0]     key_in_reg;
    logic [VALUE_BITS-1:0]   val_in_reg;

    // Per-entry state
    logic                    valid_reg [ENTRIES];
    logic                    dirty_reg [ENTRIES];
    logic [KEY_BITS-1:0]     tag_reg   [ENTRIES];
    logic [IW-1:0]           age_reg   [ENTRIES];
    logic [UW-1:0]           used_reg;

    // Memories for reads at a chosen slot
    logic [VALUE_BITS-1:0]   val_ram [ENTRIES];
    logic [KEY_BITS-1:0]     key_ram [ENTRIES];
    logic [VALUE_BITS-1:0]   val_rd_reg;
    logic [KEY_BITS-1:0]     key_rd_reg;

    // Match stage results
    logic [ENTRIES-1:0]      hit_vec, vic_vec;
    logic [ENTRIES-1:0]      hit_oh_reg, vic_oh_reg;
    logic                    hit_reg;
    logic [IW-1:0]           free_idx, free_idx_reg;
    logic                    free_any, free_ok_reg;
    logic [CW-1:0]           cap_eff;
    logic [IW-1:0]           used_m1;

    // Read stage results
    logic [IW-1:0]           hit_idx, vic_idx;
    logic [ENTRIES-1:0]      tgt_oh, tgt_oh_reg;
    logic [IW-1:0]           tgt_idx, tgt_idx_reg;
    logic                    incr_all, incr_all_reg;
    logic                    evict, evict_reg;
    logic [IW-1:0]           limit, limit_reg;

    // Result register
    logic                    m_valid_reg;
    logic                    found_reg;
    logic [VALUE_BITS-1:0]   rval_reg;
    logic                    vvalid_reg;
    logic [KEY_BITS-1:0]     vkey_reg;
    logic [VALUE_BITS-1:0]   vval_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        exec_fire  = 1'b0;
        unique case (state_reg)
            lcdw_pkg::S_IDLE: begin
                if (q_ctl.valid) begin
                    q_pop      = 1'b1;
                    state_next = lcdw_pkg::S_MATCH;
                end
            end
            lcdw_pkg::S_MATCH: state_next = lcdw_pkg::S_READ;
            lcdw_pkg::S_READ:  state_next = lcdw_pkg::S_EXEC;
            lcdw_pkg::S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    exec_fire  = 1'b1;
                    state_next = lcdw_pkg::S_IDLE;
                end
            end
            default: state_next = lcdw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcdw_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Latch item from the queue
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg    <= q_ctl.cmd;
            key_in_reg <= q_key;
            val_in_reg <= q_value;
        end
    end

    // Capacity clamp to 1..ENTRIES
    always_comb begin
        cap_eff = CW'(capacity);
        if (cap_eff == '0)
            cap_eff = CW'(1);
        else if (cap_eff > ENT_C)
            cap_eff = ENT_C;
    end

    assign used_m1 = IW'(used_reg - UW'(1));

    // Parallel key compare, LRU rank match, first free slot
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid_reg[i] && (tag_reg[i] == key_in_reg);
            vic_vec[i] = valid_reg[i] && (age_reg[i] == used_m1);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lcdw_pkg::S_MATCH) begin
            hit_oh_reg   <= hit_vec;
            vic_oh_reg   <= vic_vec;
            hit_reg      <= |hit_vec;
            free_idx_reg <= free_idx;
            free_ok_reg  <= free_any && (CW'(used_reg) < cap_eff);
        end
    end

    // One-hot to index
    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh_reg[i]) hit_idx = hit_idx | IW'(i);
            if (vic_oh_reg[i]) vic_idx = vic_idx | IW'(i);
        end
    end

    // Choose target slot
    always_comb begin
        tgt_oh   = '0;
        tgt_idx  = hit_idx;
        incr_all = 1'b0;
        evict    = 1'b0;
        priority if (cmd_reg == lcdw_pkg::CMD_NOP) begin
            tgt_oh = '0;
        end else if (hit_reg) begin
            tgt_oh = hit_oh_reg;
        end else if (cmd_reg == lcdw_pkg::CMD_PUT && free_ok_reg) begin
            tgt_idx  = free_idx_reg;
            tgt_oh   = ENTRIES'(1) << free_idx_reg;
            incr_all = 1'b1;
        end else if (cmd_reg == lcdw_pkg::CMD_PUT) begin
            tgt_idx = vic_idx;
            tgt_oh  = vic_oh_reg;
            evict   = 1'b1;
        end else begin
            tgt_oh = '0;
        end
    end

    // Rank of the target, for the recency update
    always_comb begin
        limit = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh[i]) limit = limit | age_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lcdw_pkg::S_READ) begin
            tgt_oh_reg   <= tgt_oh;
            tgt_idx_reg  <= tgt_idx;
            incr_all_reg <= incr_all;
            evict_reg    <= evict;
            limit_reg    <= limit;
            val_rd_reg   <= val_ram[tgt_idx];
            key_rd_reg   <= key_ram[tgt_idx];
        end
    end

    // Memory writes on put
    always_ff @(posedge aclk) begin
        if (exec_fire && cmd_reg == lcdw_pkg::CMD_PUT) begin
            val_ram[tgt_idx_reg] <= val_in_reg;
            key_ram[tgt_idx_reg] <= key_in_reg;
        end
    end

    // Per-lane tag and rank update
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt_oh_reg[i]) begin
                    age_reg[i] <= '0;
                    if (cmd_reg == lcdw_pkg::CMD_PUT) tag_reg[i] <= key_in_reg;
                end else if ((|tgt_oh_reg) && valid_reg[i]
                             && (incr_all_reg || age_reg[i] < limit_reg)) begin
                    age_reg[i] <= age_reg[i] + IW'(1);
                end
            end
        end
    end

    // Valid and dirty marks, fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
            end
            used_reg <= '0;
        end else if (exec_fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt_oh_reg[i]) begin
                    if (cmd_reg == lcdw_pkg::CMD_PUT) begin
                        valid_reg[i] <= 1'b1;
                        if (!hit_reg) dirty_reg[i] <= 1'b0;
                    end else if (cmd_reg == lcdw_pkg::CMD_SET_DIRTY) begin
                        dirty_reg[i] <= 1'b1;
                    end
                end
            end
            if (incr_all_reg) used_reg <= used_reg + UW'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            found_reg  <= hit_reg && (cmd_reg != lcdw_pkg::CMD_NOP);
            rval_reg   <= (hit_reg && cmd_reg == lcdw_pkg::CMD_GET) ? val_rd_reg : '0;
            vvalid_reg <= evict_reg && dirty_reg[tgt_idx_reg];
            vkey_reg   <= (evict_reg && dirty_reg[tgt_idx_reg]) ? key_rd_reg : '0;
            vval_reg   <= (evict_reg && dirty_reg[tgt_idx_reg]) ? val_rd_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = found_reg;
    assign m_read_value   = rval_reg;
    assign m_victim_valid = vvalid_reg;
    assign m_victim_key   = vkey_reg;
    assign m_victim_value = vval_reg;

`ifndef NO_ASSERTIONS
    // A key lives in at most one slot
    a_hit_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcdw_pkg::S_READ |-> $onehot0(hit_oh_reg))
        else $error("key matched in more than one slot");

    // Exactly one least recent slot when an eviction is chosen
    a_victim_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcdw_pkg::S_READ && evict |-> $onehot(vic_oh_reg))
        else $error("no unique least recent slot on eviction");

    // Fill count never exceeds the store
    a_used_max: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(ENTRIES))
        else $error("fill count beyond store size");

    // A pending result is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !exec_fire)
        else $error("result overwritten while stalled");
`endif

endmodule

// File: sv/lru_cache_dirty_writeback_unit.sv
// Top level of the LRU key/value store with dirty write-back.
// Depends on lcdw_pkg, lcdw_front, lcdw_back.
//
// Use:
//   Input channel s_valid/s_ready carries one item: s_command (0 put,
//   1 get, 2 set dirty), s_key, s_value. Result channel m_valid/m_ready
//   returns exactly one item per input: m_found, m_read_value and, for a
//   put that evicts a dirty entry, m_victim_valid/key/value for write-back.
//   cfg_we/cfg_wdata write the capacity register (reset 64); the user must
//   write it only while idle, as the block itself does not enforce this.
// Sequencer:
//   An item passes through the execution sequencer in order: dequeue, key
//   match, slot read, update; the update holds while m_ready stalls the last
//   result, and the next item is dequeued only after the update. The input
//   queue holds two items, so s_ready stays high until both entries fill.
// Reset:
//   aresetn clears all slots, dirty marks and the fill count at once.
// Stall:
//   With m_ready low one result waits in the output register; the next
//   item finishes its lookup and waits, and the queue fills, then s_ready drops.
module lru_cache_dirty_writeback_unit #(
    parameter int ENTRIES    = lcdw_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lcdw_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lcdw_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lcdw_pkg::CAP_BITS-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [KEY_BITS-1:0]           s_key,
    input  logic [VALUE_BITS-1:0]         s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [VALUE_BITS-1:0]         m_read_value,
    output logic                          m_victim_valid,
    output logic [KEY_BITS-1:0]           m_victim_key,
    output logic [VALUE_BITS-1:0]         m_victim_value
);

    logic [lcdw_pkg::CAP_BITS-1:0] capacity_reg;
    lcdw_pkg::q_ctl_t              q_ctl;
    logic [KEY_BITS-1:0]           q_key;
    logic [VALUE_BITS-1:0]         q_value;
    logic                          q_pop;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lcdw_pkg::CAP_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    lcdw_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_key     (s_key),
        .s_value   (s_value),
        .q_ctl     (q_ctl),
        .q_key     (q_key),
        .q_value   (q_value),
        .q_pop     (q_pop)
    );

    lcdw_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .capacity       (capacity_reg),
        .q_ctl          (q_ctl),
        .q_key          (q_key),
        .q_value        (q_value),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_read_value   (m_read_value),
        .m_victim_valid (m_victim_valid),
        .m_victim_key   (m_victim_key),
        .m_victim_value (m_victim_value)
    );

endmodule

// File: verif/lru_cache_dirty_writeback_unit_tb.sv
// Self-checking testbench for the LRU key/value store with dirty write-back.
// Depends on lcdw_pkg and lru_cache_dirty_writeback_unit; predicts every result in place.
`timescale 1ns / 100ps

module lru_cache_dirty_writeback_unit_tb;

    localparam int NSLOT      = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        lcdw_pkg::cmd_t cmd;
        logic [31:0]    key;
        logic [31:0]    value;
    } cache_op_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        victim_valid;
        logic [31:0] victim_key;
        logic [31:0] victim_value;
    } cache_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [31:0] s_key = '0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [31:0] m_read_value;
    logic        m_victim_valid;
    logic [31:0] m_victim_key;
    logic [31:0] m_victim_value;

    lru_cache_dirty_writeback_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_read_value  (m_read_value),
        .m_victim_valid(m_victim_valid),
        .m_victim_key  (m_victim_key),
        .m_victim_value(m_victim_value)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the store
    logic        sh_valid [NSLOT];
    logic [31:0] sh_key   [NSLOT];
    logic [31:0] sh_value [NSLOT];
    logic        sh_dirty [NSLOT];
    int          sh_age   [NSLOT];
    int          sh_used;
    logic [6:0]  sh_capacity;

    cache_op_t   pending_ops[$];
    cache_resp_t expected_resps[$];
    logic [31:0] known_keys[$];
    int          mismatches = 0;
    int          idle_cycles = 0;

    // Move slot s to the front of the recency order
    function automatic void refresh_slot(int s);
        int lim;
        lim = sh_age[s];
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && i != s && sh_age[i] < lim) sh_age[i]++;
        sh_age[s] = 0;
    endfunction

    function automatic cache_resp_t lru_predict(cache_op_t op);
        cache_resp_t r;
        int hit, slot, cap, best;
        bit any;
        r = '0;
        hit = -1;
        for (int i = 0; i < NSLOT; i++)
            if (hit < 0 && sh_valid[i] && sh_key[i] == op.key) hit = i;
        cap = sh_capacity;
        if (cap < 1) cap = 1;
        if (cap > NSLOT) cap = NSLOT;
        case (op.cmd)
            lcdw_pkg::CMD_PUT: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    sh_value[hit] = op.value;
                    refresh_slot(hit);
                end else begin
                    slot = -1;
                    if (sh_used < cap)
                        for (int i = 0; i < NSLOT; i++)
                            if (slot < 0 && !sh_valid[i]) slot = i;
                    if (slot >= 0) begin
                        for (int i = 0; i < NSLOT; i++)
                            if (sh_valid[i]) sh_age[i]++;
                        sh_used++;
                    end else begin
                        best = 0;
                        any = 1'b0;
                        for (int i = 0; i < NSLOT; i++)
                            if (sh_valid[i] && (!any || sh_age[i] > sh_age[best])) begin
                                best = i;
                                any = 1'b1;
                            end
                        slot = best;
                        if (any && sh_dirty[best]) begin
                            r.victim_valid = 1'b1;
                            r.victim_key   = sh_key[best];
                            r.victim_value = sh_value[best];
                        end
                        if (!any) sh_used++;
                        refresh_slot(best);
                    end
                    sh_valid[slot] = 1'b1;
                    sh_key[slot]   = op.key;
                    sh_value[slot] = op.value;
                    sh_dirty[slot] = 1'b0;
                    sh_age[slot]   = 0;
                end
            end
            lcdw_pkg::CMD_GET: if (hit >= 0) begin
                r.found = 1'b1;
                r.read_value = sh_value[hit];
                refresh_slot(hit);
            end
            lcdw_pkg::CMD_SET_DIRTY: if (hit >= 0) begin
                r.found = 1'b1;
                sh_dirty[hit] = 1'b1;
                refresh_slot(hit);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(0, 3);
    endfunction

    // Queues one item; pick_key below draws keys mostly from a small reused set so hits and evictions are common
    task automatic queue_op(lcdw_pkg::cmd_t c, logic [31:0] k, logic [31:0] v);
        cache_op_t op;
        op.cmd = c;
        op.key = k;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7 && known_keys.size() > 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return $urandom();
    endfunction

    // Driver: feeds queued items with random gaps
    int in_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(lru_predict(cache_op_t'({s_command, s_key, s_value})));
            end
            if (!s_valid || s_ready) begin
                if (in_gap > 0 || pending_ops.size() == 0) begin
                    s_valid <= 1'b0;
                    if (in_gap > 0) in_gap <= in_gap - 1;
                end else begin
                    cache_op_t op;
                    op = pending_ops.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= op.cmd;
                    s_key     <= op.key;
                    s_value   <= op.value;
                    in_gap    <= pick_gap();
                end
            end
        end
    end

    // Monitor: checks results against predictions, with random back-pressure
    int out_gap = 0;
    always @(posedge aclk) begin
        cache_resp_t want, got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_found, m_read_value, m_victim_valid, m_victim_key, m_victim_value};
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result item %p", got);
                end else begin
                    want = expected_resps.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("Mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                m_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else begin
                m_ready <= 1'b1;
                out_gap <= pick_gap();
            end
            // Watchdog on accepted items
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (pending_ops.size() == 0 && !s_valid && expected_resps.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_capacity(logic [6:0] c);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sh_capacity = c;
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || expected_resps.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Random phase of n items with capacity cap
    task automatic random_phase(logic [6:0] cap, int n);
        int sel;
        logic [31:0] k;
        write_capacity(cap);
        known_keys.delete();
        for (int i = 0; i < 24; i++) known_keys.push_back($urandom());
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            k = pick_key();
            if (sel < 45) queue_op(lcdw_pkg::CMD_PUT, k, $urandom());
            else if (sel < 70) queue_op(lcdw_pkg::CMD_GET, k, $urandom());
            else if (sel < 95) queue_op(lcdw_pkg::CMD_SET_DIRTY, k, $urandom());
            else queue_op(lcdw_pkg::CMD_NOP, k, $urandom());
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            sh_valid[i] = 1'b0;
            sh_key[i]   = '0;
            sh_value[i] = '0;
            sh_dirty[i] = 1'b0;
            sh_age[i]   = 0;
        end
        sh_used = 0;
        sh_capacity = lcdw_pkg::CAP_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: misses on empty store, extremes, dirty eviction at capacity 2
        write_capacity(7'd2);
        queue_op(lcdw_pkg::CMD_GET, 32'h0, 32'hFFFF_FFFF);
        queue_op(lcdw_pkg::CMD_SET_DIRTY, 32'hFFFF_FFFF, 32'h0);
        queue_op(lcdw_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
        queue_op(lcdw_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0);
        queue_op(lcdw_pkg::CMD_GET, 32'h0, 32'h0);
        queue_op(lcdw_pkg::CMD_SET_DIRTY, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_op(lcdw_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        queue_op(lcdw_pkg::CMD_PUT, 32'h5555_AAAA, 32'h1);
        queue_op(lcdw_pkg::CMD_PUT, 32'hAAAA_5555, 32'h2);
        queue_op(lcdw_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(lcdw_pkg::CMD_GET, 32'h5555_AAAA, 32'h0);
        queue_op(lcdw_pkg::CMD_GET, 32'hAAAA_5555, 32'h0);
        wait_drained();
        // Capacity zero acts as one, with use above the limit
        write_capacity(7'd0);
        queue_op(lcdw_pkg::CMD_SET_DIRTY, 32'hAAAA_5555, 32'h0);
        queue_op(lcdw_pkg::CMD_PUT, 32'h1, 32'h3);
        queue_op(lcdw_pkg::CMD_PUT, 32'h2, 32'h4);
        queue_op(lcdw_pkg::CMD_GET, 32'h1, 32'h0);
        wait_drained();

        random_phase(7'd127, 300);
        random_phase(7'd1, 200);
        random_phase(7'd8, 400);
        random_phase(7'd64, 300);
        random_phase(7'd16, 300);
        random_phase(7'd3, 200);

        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/lcdw_pkg.sv
sv/lcdw_front.sv
sv/lcdw_back.sv
sv/lru_cache_dirty_writeback_unit.sv
verif/lru_cache_dirty_writeback_unit_tb.sv
